FILE: src/nfw_pkg.sv
// Shared types and constants of the node filter and weight block.
`default_nettype none
package nfw_pkg;

	localparam logic [1:0] REG_MIN_DEPOSIT    = 2'd0;
	localparam logic [1:0] REG_REQUIRED_PROPS = 2'd1;
	localparam logic [1:0] REG_WHITELIST      = 2'd2;
	localparam logic [1:0] REG_FILTER_LIST    = 2'd3;

	localparam logic [63:0] RECOVERY_SECONDS = 64'd604800;
	// factor = diff / 6048, done as a multiply by 2^32/6048 and one fixup
	localparam logic [19:0] FAC_RECIP   = 20'd710146;
	localparam logic [19:0] FAC_DIVISOR = 20'd6048;
	localparam logic [6:0]  FAC_FULL    = 7'd100;
	// x / 100 as a multiply by 2^32/100 and one fixup
	localparam logic [25:0] PCT_RECIP   = 26'd42949672;
	localparam logic [23:0] PCT_DIVISOR = 24'd100;
	localparam logic [30:0] CAPA_FLOOR  = 31'd100;
	localparam logic [31:0] CAPA_BIAS   = 32'd100;
	localparam logic [30:0] COUNT_MIN   = 31'd4;
	// dividends pre-aligned to the top of the divider word
	localparam logic [31:0] DVD_CAPA    = 32'd10000 << 18;
	localparam logic [5:0]  ITER_CAPA   = 6'd14;
	localparam logic [5:0]  ITER_RATIO  = 6'd31;
	localparam logic [31:0] DVD_WMAX    = 32'h0000FFFF << 16;
	localparam logic [5:0]  ITER_WMAX   = 6'd16;

	typedef struct packed {
		logic        keep;
		logic        last;
		logic        near;
		logic [19:0] diff;
		logic        ratio;
		logic [30:0] total;
		logic [31:0] dvs;
	} item_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dvd;
		logic [31:0] dvs;
		logic [5:0]  iters;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
	} div_rsp_t;

endpackage
`default_nettype wire

FILE: src/nfw_front.sv
// Front end: configuration registers, request intake and filter decision.
`default_nettype none
module nfw_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [63:0]  cfg_data,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [63:0]  now_seconds,
	input  wire logic [63:0]  ban_expiry,
	input  wire logic         is_boot_node,
	input  wire logic         is_whitelisted,
	input  wire logic         in_node_filter,
	input  wire logic [63:0]  node_deposit,
	input  wire logic [63:0]  prop_bits,
	input  wire logic [30:0]  node_capacity,
	input  wire logic [30:0]  resp_count,
	input  wire logic [30:0]  resp_time_sum,
	input  wire logic         last_node,
	input  wire logic         q_full,
	output logic              push,
	output nfw_pkg::item_t    push_item
);

	logic [63:0] min_dep_q;
	logic [63:0] req_props_q;
	logic        wl_q;
	logic        flt_q;
	logic        props_ok;
	logic        gen_ok;
	logic [63:0] diff;
	logic [30:0] capa_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dep_q   <= '0;
			req_props_q <= '0;
			wl_q        <= 1'b0;
			flt_q       <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				nfw_pkg::REG_MIN_DEPOSIT:    min_dep_q   <= cfg_data;
				nfw_pkg::REG_REQUIRED_PROPS: req_props_q <= cfg_data;
				nfw_pkg::REG_WHITELIST:      wl_q        <= cfg_data[0];
				nfw_pkg::REG_FILTER_LIST:    flt_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		props_ok = ((req_props_q[31:0] & prop_bits[31:0]) == req_props_q[31:0]) &&
			((req_props_q[63:32] == 32'd0) || (prop_bits[63:32] <= req_props_q[63:32]));
		gen_ok = !(wl_q && !is_whitelisted) && (node_deposit >= min_dep_q) && props_ok;
		diff   = now_seconds - ban_expiry;
		capa_c = (node_capacity < nfw_pkg::CAPA_FLOOR) ? nfw_pkg::CAPA_FLOOR : node_capacity;
		push_item.keep  = !(flt_q && !in_node_filter) && !(ban_expiry > now_seconds) &&
			(is_boot_node || gen_ok);
		push_item.last  = last_node;
		push_item.near  = diff < nfw_pkg::RECOVERY_SECONDS;
		push_item.diff  = diff[19:0];
		push_item.ratio = (resp_count > nfw_pkg::COUNT_MIN) && (resp_time_sum != 31'd0);
		push_item.total = resp_time_sum;
		push_item.dvs   = push_item.ratio ? {1'b0, resp_count} :
			({1'b0, capa_c} + nfw_pkg::CAPA_BIAS);
	end

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

endmodule
`default_nettype wire

FILE: src/nfw_queue.sv
// Two-entry queue between front end and back end.
`default_nettype none
module nfw_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire nfw_pkg::item_t  push_item,
	output logic                 full,
	input  wire logic            pop,
	output logic                 head_valid,
	output nfw_pkg::item_t       head
);

	nfw_pkg::item_t mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_item;
	end

	assign full       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head       = mem_q[rp_q];

endmodule
`default_nettype wire

FILE: src/nfw_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module nfw_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire nfw_pkg::div_req_t  req,
	output nfw_pkg::div_rsp_t       rsp
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [32:0] trial;
	logic        ge;

	assign trial = {rem_q, quo_q[31]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= req.iters;
			done_q <= 1'b0;
		end else begin
			done_q <= cnt_q == 6'd1;
			if (cnt_q != 6'd0) cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dvd;
			dvs_q <= req.dvs;
		end else if (cnt_q != 6'd0) begin
			rem_q <= ge ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule
`default_nettype wire

FILE: src/nfw_back.sv
// Back end: weight sequencer, prefix sum, counters and output register.
`default_nettype none
module nfw_back #(
	parameter int MAX_NODES = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               head_valid,
	input  wire nfw_pkg::item_t     head,
	output logic                    pop,
	output nfw_pkg::div_req_t       dreq,
	input  wire nfw_pkg::div_rsp_t  drsp,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [7:0]              node_position,
	output logic                    selected,
	output logic [31:0]             range_start,
	output logic [15:0]             node_weight,
	output logic [31:0]             weight_total,
	output logic [8:0]              found_count,
	output logic                    pass_done
);

	localparam logic [8:0] CNT_CAP = 9'((MAX_NODES < 511) ? MAX_NODES : 511);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DIV1 = 7'b0000010,
		ST_DIV2 = 7'b0000100,
		ST_WMUL = 7'b0001000,
		ST_WREC = 7'b0010000,
		ST_WFIX = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t         state_q;
	nfw_pkg::item_t cur_q;
	logic [39:0]    fprod_s1;
	logic [7:0]     fq_s2;
	logic [6:0]     fac_q;
	logic [15:0]    wq_q;
	logic [22:0]    wprod_q;
	logic [16:0]    west_q;
	logic [15:0]    w_q;
	logic [7:0]     pos_q;
	logic [31:0]    sum_q;
	logic [8:0]     cnt_q;
	logic           out_valid_q;
	logic           load;
	logic [19:0]    frem;
	logic [48:0]    wrec;
	logic [23:0]    wback;
	logic [31:0]    sum_new;
	logic [8:0]     cnt_new;

	// factor pipeline runs freely; it settles long before the first division ends
	always_ff @(posedge clk) begin
		fprod_s1 <= cur_q.diff * nfw_pkg::FAC_RECIP;
		fq_s2    <= fprod_s1[39:32];
		if (!cur_q.near)
			fac_q <= nfw_pkg::FAC_FULL;
		else if (frem >= nfw_pkg::FAC_DIVISOR)
			fac_q <= fq_s2[6:0] + 7'd1;
		else
			fac_q <= fq_s2[6:0];
	end
	assign frem = cur_q.diff - 20'(fq_s2 * nfw_pkg::FAC_DIVISOR);

	assign wrec    = wprod_q * nfw_pkg::PCT_RECIP;
	assign wback   = 24'(west_q) * nfw_pkg::PCT_DIVISOR;
	assign load    = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign pop     = (state_q == ST_IDLE) && head_valid;
	assign sum_new = cur_q.keep ? sum_q + {16'd0, w_q} : sum_q;
	assign cnt_new = (cur_q.keep && cnt_q < CNT_CAP) ? cnt_q + 9'd1 : cnt_q;

	always_comb begin
		dreq = '0;
		if (pop && head.keep) begin
			dreq.start = 1'b1;
			dreq.dvd   = head.ratio ? {head.total, 1'b0} : nfw_pkg::DVD_CAPA;
			dreq.dvs   = head.dvs;
			dreq.iters = head.ratio ? nfw_pkg::ITER_RATIO : nfw_pkg::ITER_CAPA;
		end else if (state_q == ST_DIV1 && drsp.done) begin
			// an average of zero counts as one
			dreq.start = 1'b1;
			dreq.dvd   = nfw_pkg::DVD_WMAX;
			dreq.dvs   = (drsp.quo == 32'd0) ? 32'd1 : drsp.quo;
			dreq.iters = nfw_pkg::ITER_WMAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				pos_q       <= cur_q.last ? 8'd0 : pos_q + 8'd1;
				sum_q       <= cur_q.last ? 32'd0 : sum_new;
				cnt_q       <= cur_q.last ? 9'd0 : cnt_new;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (pop) state_q <= head.keep ? ST_DIV1 : ST_DONE;
				ST_DIV1: if (drsp.done) state_q <= ST_DIV2;
				ST_DIV2: if (drsp.done) state_q <= ST_WMUL;
				ST_WMUL: state_q <= ST_WREC;
				ST_WREC: state_q <= ST_WFIX;
				ST_WFIX: state_q <= ST_DONE;
				ST_DONE: if (load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
		if (pop) w_q <= '0;
		if (state_q == ST_DIV2 && drsp.done) wq_q <= drsp.quo[15:0];
		if (state_q == ST_WMUL) wprod_q <= wq_q * fac_q;
		if (state_q == ST_WREC) west_q <= wrec[48:32];
		if (state_q == ST_WFIX)
			w_q <= ({1'b0, wprod_q} - wback >= nfw_pkg::PCT_DIVISOR) ?
				16'(west_q + 17'd1) : west_q[15:0];
		if (load) begin
			node_position <= pos_q;
			selected      <= cur_q.keep;
			range_start   <= sum_q;
			node_weight   <= w_q;
			weight_total  <= sum_new;
			found_count   <= cnt_new;
			pass_done     <= cur_q.last;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: src/node_filter_weight_prefix_core.sv
// Node filter with weight computation and running prefix sum: top level.
//
// Requests arrive on in_valid/in_ready, one node record each; every request
// yields exactly one result on out_valid/out_ready, in order. Configuration
// writes use cfg_valid/cfg_index/cfg_data; cfg_ready is always high and
// writes are expected only while the block is idle.
// A dropped node skips both divisions and passes to the output register, and
// the back end takes the next node only once that result is loaded. A kept
// node runs two divisions on one shared bit-serial divider, first for the
// average and then for the weight, followed by the multiply, reciprocal and
// fixup steps, and the next node is again taken only after its result loads.
// A two-entry queue lets the front take requests while the back is busy.
// The result sits in an output register; the back may finish the next node
// while it waits and holds it until the receiver takes the current one.
// A stalled receiver therefore backs up the queue, then in_ready drops.
// Reset clears the configuration, the position, sum and found counters and
// all valid flags; no clearing pass is needed. The counters return to zero
// after the result flagged pass_done.
`default_nettype none
module node_filter_weight_prefix_core #(
	parameter int MAX_NODES = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [63:0]  cfg_data,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [63:0]  now_seconds,
	input  wire logic [63:0]  ban_expiry,
	input  wire logic         is_boot_node,
	input  wire logic         is_whitelisted,
	input  wire logic         in_node_filter,
	input  wire logic [63:0]  node_deposit,
	input  wire logic [63:0]  prop_bits,
	input  wire logic [30:0]  node_capacity,
	input  wire logic [30:0]  resp_count,
	input  wire logic [30:0]  resp_time_sum,
	input  wire logic         last_node,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [7:0]        node_position,
	output logic              selected,
	output logic [31:0]       range_start,
	output logic [15:0]       node_weight,
	output logic [31:0]       weight_total,
	output logic [8:0]        found_count,
	output logic              pass_done
);

	logic              q_full;
	logic              push;
	nfw_pkg::item_t    push_item;
	logic              pop;
	logic              head_valid;
	nfw_pkg::item_t    head;
	nfw_pkg::div_req_t dreq;
	nfw_pkg::div_rsp_t drsp;

	nfw_front u_front (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .now_seconds, .ban_expiry, .is_boot_node,
		.is_whitelisted, .in_node_filter, .node_deposit, .prop_bits,
		.node_capacity, .resp_count, .resp_time_sum, .last_node,
		.q_full, .push, .push_item
	);

	nfw_queue u_queue (
		.clk, .arst_n, .push, .push_item, .full(q_full), .pop, .head_valid, .head
	);

	nfw_div u_div (
		.clk, .arst_n, .req(dreq), .rsp(drsp)
	);

	nfw_back #(.MAX_NODES(MAX_NODES)) u_back (
		.clk, .arst_n, .head_valid, .head, .pop, .dreq, .drsp,
		.out_valid, .out_ready, .node_position, .selected, .range_start,
		.node_weight, .weight_total, .found_count, .pass_done
	);

endmodule
`default_nettype wire

FILE: src/nfw_checker.sv
// Port-level checks of the core, attached by bind.
`default_nettype none
module nfw_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        selected,
	input wire logic [7:0]  node_position,
	input wire logic [31:0] range_start,
	input wire logic [15:0] node_weight,
	input wire logic [31:0] weight_total
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(weight_total) && $stable(node_position))
		else $error("result changed while stalled");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !selected |-> node_weight == 16'd0 && range_start == weight_total)
		else $error("dropped node moved the sum");

	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && selected |-> weight_total == 32'(range_start + {16'd0, node_weight}))
		else $error("prefix sum mismatch");

endmodule

bind node_filter_weight_prefix_core nfw_checker u_nfw_checker (
	.clk, .arst_n, .out_valid, .out_ready, .selected, .node_position,
	.range_start, .node_weight, .weight_total
);
`default_nettype wire

FILE: tb/testbench.sv
// Testbench for node_filter_weight_prefix_core: random node lists checked against a predictor.
`default_nettype none

class node_scoreboard;
	typedef struct {
		logic [7:0]  pos;
		logic        sel;
		logic [31:0] start;
		logic [15:0] weight;
		logic [31:0] total;
		logic [8:0]  found;
		logic        done;
	} node_result_t;

	logic [63:0] deposit_floor;
	logic [63:0] required_props;
	logic        whitelist_on;
	logic        filter_on;
	logic [7:0]  position;
	logic [31:0] running_sum;
	logic [8:0]  kept_count;
	node_result_t expected_results[$];
	int errors;

	function new();
		deposit_floor = '0;
		required_props = '0;
		whitelist_on = 1'b0;
		filter_on = 1'b0;
		position = '0;
		running_sum = '0;
		kept_count = '0;
		errors = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [63:0] data);
		case (idx)
			nfw_pkg::REG_MIN_DEPOSIT:    deposit_floor = data;
			nfw_pkg::REG_REQUIRED_PROPS: required_props = data;
			nfw_pkg::REG_WHITELIST:      whitelist_on = data[0];
			nfw_pkg::REG_FILTER_LIST:    filter_on = data[0];
			default: ;
		endcase
	endfunction

	function logic [15:0] weight_of(logic [63:0] now, logic [63:0] ban_end, logic [30:0] capa,
			logic [30:0] cnt, logic [30:0] tot);
		logic [31:0] avg;
		logic [31:0] c;
		logic [63:0] diff;
		logic [63:0] factor;
		logic [63:0] w;
		if (cnt > 4 && tot != 0) begin
			avg = 32'(tot) / 32'(cnt);
		end else begin
			c = (capa < 100) ? 32'd100 : 32'(capa);
			avg = 32'd10000 / (c + 32'd100);
		end
		if (avg == 0) avg = 1;
		diff = now - ban_end;
		factor = (diff < 64'd604800) ? (diff * 100) / 64'd604800 : 64'd100;
		w = ((64'hFFFF / 64'(avg)) * factor) / 100;
		return w[15:0];
	endfunction

	function void note_request(logic [63:0] now, logic [63:0] ban_end, logic boot, logic white,
			logic in_filt, logic [63:0] dep, logic [63:0] props, logic [30:0] capa,
			logic [30:0] cnt, logic [30:0] tot, logic last);
		node_result_t r;
		logic keep;
		keep = 1'b1;
		if (filter_on && !in_filt) keep = 1'b0;
		if (keep && ban_end > now) keep = 1'b0;
		if (keep && !boot) begin
			if (whitelist_on && !white) keep = 1'b0;
			else if (dep < deposit_floor) keep = 1'b0;
			else if ((required_props[31:0] & props[31:0]) != required_props[31:0]) keep = 1'b0;
			else if (required_props[63:32] != 0 && props[63:32] > required_props[63:32])
				keep = 1'b0;
		end
		r.pos = position;
		r.sel = keep;
		r.start = running_sum;
		r.weight = keep ? weight_of(now, ban_end, capa, cnt, tot) : 16'd0;
		running_sum = running_sum + 32'(r.weight);
		if (keep && kept_count < 256) kept_count++;
		r.total = running_sum;
		r.found = kept_count;
		r.done = last;
		expected_results.push_back(r);
		position++;
		if (last) begin
			position = '0;
			running_sum = '0;
			kept_count = '0;
		end
	endfunction

	function void check_result(logic [7:0] pos, logic sel, logic [31:0] start,
			logic [15:0] weight, logic [31:0] total, logic [8:0] found, logic done);
		node_result_t e;
		if (expected_results.size() == 0) begin
			$display("%0t unexpected result pos=%0d", $time, pos);
			errors++;
			return;
		end
		e = expected_results.pop_front();
		if (pos !== e.pos) begin
			$display("%0t node_position exp %0d got %0d", $time, e.pos, pos); errors++;
		end
		if (sel !== e.sel) begin
			$display("%0t selected exp %0d got %0d", $time, e.sel, sel); errors++;
		end
		if (start !== e.start) begin
			$display("%0t range_start exp %0h got %0h", $time, e.start, start); errors++;
		end
		if (weight !== e.weight) begin
			$display("%0t node_weight exp %0d got %0d", $time, e.weight, weight); errors++;
		end
		if (total !== e.total) begin
			$display("%0t weight_total exp %0h got %0h", $time, e.total, total); errors++;
		end
		if (found !== e.found) begin
			$display("%0t found_count exp %0d got %0d", $time, e.found, found); errors++;
		end
		if (done !== e.done) begin
			$display("%0t pass_done exp %0d got %0d", $time, e.done, done); errors++;
		end
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [63:0] now_seconds = '0;
	logic [63:0] ban_expiry = '0;
	logic is_boot_node = 1'b0;
	logic is_whitelisted = 1'b0;
	logic in_node_filter = 1'b0;
	logic [63:0] node_deposit = '0;
	logic [63:0] prop_bits = '0;
	logic [30:0] node_capacity = '0;
	logic [30:0] resp_count = '0;
	logic [30:0] resp_time_sum = '0;
	logic last_node = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] node_position;
	logic selected;
	logic [31:0] range_start;
	logic [15:0] node_weight;
	logic [31:0] weight_total;
	logic [8:0] found_count;
	logic pass_done;

	node_scoreboard sb = new();
	int idle_cycles = 0;
	int stall_mode = 0;      // 0 random, 1 always ready, 2 long hold-off
	logic [63:0] pass_now = 64'd1_000_000_000;

	always #10 clk = ~clk;

	node_filter_weight_prefix_core u_dut (.*);

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(node_position, selected, range_start, node_weight,
				weight_total, found_count, pass_done);
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk) begin
		case (stall_mode)
			1: out_ready <= 1'b1;
			2: out_ready <= 1'b0;
			default: out_ready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic write_cfg(logic [1:0] idx, logic [63:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.expected_results.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic send_node(logic [63:0] now, logic [63:0] ban_end, logic boot, logic white,
			logic filt, logic [63:0] dep, logic [63:0] props, logic [30:0] capa,
			logic [30:0] cnt, logic [30:0] tot, logic last);
		now_seconds <= now;
		ban_expiry <= ban_end;
		is_boot_node <= boot;
		is_whitelisted <= white;
		in_node_filter <= filt;
		node_deposit <= dep;
		prop_bits <= props;
		node_capacity <= capa;
		resp_count <= cnt;
		resp_time_sum <= tot;
		last_node <= last;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_request(now, ban_end, boot, white, filt, dep, props, capa, cnt, tot, last);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_random(logic last);
		logic [63:0] ban_end;
		logic [63:0] props;
		case ($urandom_range(0, 4))
			0: ban_end = {$urandom, $urandom};
			1: ban_end = pass_now - $urandom_range(0, 700000);
			2: ban_end = pass_now;
			default: ban_end = $urandom_range(0, 1) ? 64'd0 : pass_now - 64'd604800;
		endcase
		props = {$urandom, $urandom};
		if ($urandom_range(0, 2) != 0) props[31:0] = props[31:0] | sb.required_props[31:0];
		if ($urandom_range(0, 1)) props[63:32] = $urandom_range(0, 1000);
		send_node(pass_now, ban_end, $urandom_range(0, 3) == 0, $urandom_range(0, 3) != 0,
			$urandom_range(0, 3) != 0,
			$urandom_range(0, 3) == 0 ? {$urandom, $urandom} : 64'($urandom_range(0, 2000)),
			props,
			$urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 300)),
			$urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 8)),
			$urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 2000)),
			last);
	endtask

	initial begin
		int burst;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, boot bypass, zero average, recovery factor edges
		send_node('1, '1, 1, 0, 0, '1, '1, '1, '1, '1, 0);
		send_node('1, 64'hFFFF_FFFF_FFFF_FFFE, 0, 1, 1, 0, 0, 0, 0, 0, 0);
		send_node(64'd0, 64'd1, 1, 1, 1, '0, '0, '0, '0, '0, 0);
		send_node(64'd604800, 64'd0, 0, 0, 0, '0, '0, 31'd5000, 31'd5, 31'd1, 0);
		send_node(64'd604799, 64'd0, 0, 0, 0, '0, '0, 31'd0, 31'd4, 31'd100, 0);
		send_node(64'd1000, 64'd1000, 1, 0, 0, '0, '0, 31'd99, 31'd5, 31'd0, 0);
		send_node(64'd5000, 64'd0, 0, 0, 0, '0, '0, 31'd0, 31'h7FFFFFFF, 31'h7FFFFFFF, 1);
		wait_drained();

		write_cfg(nfw_pkg::REG_MIN_DEPOSIT, '1);
		write_cfg(nfw_pkg::REG_REQUIRED_PROPS, '1);
		write_cfg(nfw_pkg::REG_WHITELIST, 64'd1);
		write_cfg(nfw_pkg::REG_FILTER_LIST, 64'd1);
		send_node('1, 0, 0, 1, 1, '1, '1, 31'd10, 31'd10, 31'd10, 0);
		send_node('1, 0, 0, 1, 1, 64'hFFFF_FFFF_FFFF_FFFE, '1, 31'd10, 31'd10, 31'd10, 0);
		send_node('1, 0, 0, 0, 1, '1, '1, 31'd10, 31'd10, 31'd10, 0);
		send_node('1, 0, 1, 0, 1, 0, 0, 31'd10, 31'd10, 31'd10, 0);
		send_node('1, 0, 1, 1, 0, '1, '1, 31'd10, 31'd10, 31'd10, 1);
		wait_drained();

		// long pass: position wraps, found count saturates
		write_cfg(nfw_pkg::REG_MIN_DEPOSIT, '0);
		write_cfg(nfw_pkg::REG_REQUIRED_PROPS, '0);
		write_cfg(nfw_pkg::REG_WHITELIST, 64'd0);
		write_cfg(nfw_pkg::REG_FILTER_LIST, 64'd0);
		stall_mode = 1;
		for (int i = 0; i < 260; i++)
			send_node(64'd1000, 64'd0, 1, 0, 0, 0, 0, 31'd0, 31'd0, 31'd0, i == 259);
		wait_drained();

		// hold off the receiver so the queue fills and in_ready drops
		stall_mode = 2;
		fork
			begin
				repeat (300) @(negedge clk);
				stall_mode = 0;
			end
			for (int i = 0; i < 6; i++) send_random(i == 5);
		join
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_cfg(nfw_pkg::REG_MIN_DEPOSIT, 64'd500);
					write_cfg(nfw_pkg::REG_REQUIRED_PROPS, {32'd500, 32'h0000_0013});
					write_cfg(nfw_pkg::REG_WHITELIST, 64'd1);
					write_cfg(nfw_pkg::REG_FILTER_LIST, 64'd0);
				end
				1: begin
					write_cfg(nfw_pkg::REG_MIN_DEPOSIT, 64'd0);
					write_cfg(nfw_pkg::REG_REQUIRED_PROPS, 64'd0);
					write_cfg(nfw_pkg::REG_WHITELIST, 64'd0);
					write_cfg(nfw_pkg::REG_FILTER_LIST, 64'd1);
				end
				2: begin
					write_cfg(nfw_pkg::REG_MIN_DEPOSIT, {$urandom, $urandom});
					write_cfg(nfw_pkg::REG_REQUIRED_PROPS, {32'd0, 32'h8000_0001});
					write_cfg(nfw_pkg::REG_WHITELIST, 64'd1);
					write_cfg(nfw_pkg::REG_FILTER_LIST, 64'd1);
				end
				default: begin
					write_cfg(nfw_pkg::REG_MIN_DEPOSIT, 64'd1000);
					write_cfg(nfw_pkg::REG_REQUIRED_PROPS, {32'd1, 32'd0});
					write_cfg(nfw_pkg::REG_WHITELIST, 64'd0);
					write_cfg(nfw_pkg::REG_FILTER_LIST, 64'd0);
				end
			endcase
			stall_mode = (ph == 3) ? 1 : 0;
			for (int k = 0; k < 30; k++) begin
				if (k % 10 == 0) pass_now = {$urandom, $urandom};
				send_random((k % 10 == 9) || ($urandom_range(0, 15) == 0));
				burst = $urandom_range(0, 5);
				if (burst == 0) repeat ($urandom_range(1, 60)) @(negedge clk);
			end
			wait_drained();
		end

		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
